// ----- rtl/qrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared constants and types of the quadratic root solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int QRS_COEF_WIDTH = 32;
   localparam int QRS_FRAC_BITS  = 16;

   typedef enum logic [1:0] {
      KIND_REAL       = 2'd0,
      KIND_COMPLEX    = 2'd1,
      KIND_DEGENERATE = 2'd2
   } root_kind_type;

   // Control that travels with a word from the input stage to the numerators.
   typedef struct packed {
      logic valid;
      logic sa;
      logic sb;
      logic sc;
      logic dneg;
   } front_ctl_type;

   // Control that travels with a word through the dividers.
   typedef struct packed {
      logic valid;
      logic degen;
      logic cplx;
      logic neg1;
      logic neg2;
   } div_ctl_type;

endpackage
`default_nettype wire

// ----- rtl/qrs_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_isqrt
// Pipelined integer square root, rounded down, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_isqrt import qrs_pkg::*; #(
   parameter int RAD_WIDTH = 2 * QRS_COEF_WIDTH + 2
) (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire logic [RAD_WIDTH-1:0]   rad_in,
   output logic      [RAD_WIDTH/2-1:0] root_out
);

   localparam int SQ  = RAD_WIDTH / 2;
   localparam int RMW = SQ + 2;
   localparam int TW  = RMW + 2;

   logic [RMW-1:0]       rem_ff  [SQ];
   logic [SQ-1:0]        root_ff [SQ];
   logic [RAD_WIDTH-1:0] rad_ff  [SQ];

   for (genvar k = 0; k < SQ; k++) begin : g_stage
      logic [RMW-1:0]       rem_prev;
      logic [SQ-1:0]        root_prev;
      logic [RAD_WIDTH-1:0] rad_prev;
      logic [TW-1:0]        t;
      logic [TW-1:0]        trial;
      logic                 ge;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = rad_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
      end

      assign t     = {rem_prev, rad_prev[RAD_WIDTH-1 -: 2]};
      assign trial = TW'({root_prev, 2'b01});
      assign ge    = (t >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? RMW'(t - trial) : RMW'(t);
            root_ff[k] <= {root_prev[SQ-2:0], ge};
            rad_ff[k]  <= rad_prev << 2;
         end
      end
   end

   assign root_out = root_ff[SQ-1];

endmodule
`default_nettype wire

// ----- rtl/qrs_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider for unsigned operands, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div import qrs_pkg::*; #(
   parameter int NUM_WIDTH = QRS_COEF_WIDTH + 2 + QRS_FRAC_BITS,
   parameter int DEN_WIDTH = QRS_COEF_WIDTH + 1
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [NUM_WIDTH-1:0] num_in,
   input  wire logic [DEN_WIDTH-1:0] den_in,
   output logic      [NUM_WIDTH-1:0] quo_out
);

   localparam int TW = DEN_WIDTH + 1;

   logic [DEN_WIDTH-1:0] rem_ff [NUM_WIDTH];
   logic [DEN_WIDTH-1:0] den_ff [NUM_WIDTH];
   // Upper part holds the dividend bits not yet used, lower part the quotient.
   logic [NUM_WIDTH-1:0] qn_ff  [NUM_WIDTH];

   for (genvar k = 0; k < NUM_WIDTH; k++) begin : g_stage
      logic [DEN_WIDTH-1:0] rem_prev;
      logic [DEN_WIDTH-1:0] den_prev;
      logic [NUM_WIDTH-1:0] qn_prev;
      logic [TW-1:0]        t;
      logic [TW-1:0]        d;
      logic                 ge;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign den_prev = den_in;
         assign qn_prev  = num_in;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign qn_prev  = qn_ff[k-1];
      end

      assign t  = {rem_prev, qn_prev[NUM_WIDTH-1]};
      assign d  = {1'b0, den_prev};
      assign ge = (t >= d);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? DEN_WIDTH'(t - d) : DEN_WIDTH'(t);
            den_ff[k] <= den_prev;
            qn_ff[k]  <= {qn_prev[NUM_WIDTH-2:0], ge};
         end
      end
   end

   assign quo_out = qn_ff[NUM_WIDTH-1];

endmodule
`default_nettype wire

// ----- rtl/quadratic_root_solver.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2 + b*x + c in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// From accepted word to result word, a word passes the input stage, the
// products, discriminant, square root, numerators, dividers and output
// register; the square root takes one stage per root bit and each divider
// one stage per quotient bit. Throughput: one word per cycle; the whole
// pipeline holds while a result waits on rsp_tready.
// Reset clears all valid bits; the pipeline is empty afterwards.
module quadratic_root_solver import qrs_pkg::*; #(
   parameter int COEF_WIDTH = QRS_COEF_WIDTH,
   parameter int FRAC_BITS  = QRS_FRAC_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // coef_a, coef_b, coef_c from the lowest bit up, zero padded to bytes
   input  wire logic [((3*COEF_WIDTH+7)/8)*8-1:0]     req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // first_value, second_value from the lowest bit up, zero padded to bytes
   output logic      [((2*COEF_WIDTH+7)/8)*8-1:0]     rsp_tdata,
   // root_kind (2 bits), saturated from the lowest bit up
   output logic      [2:0]                            rsp_tuser
);

   localparam int W    = COEF_WIDTH;
   localparam int RW   = 2 * W + 2;
   localparam int SQ   = RW / 2;
   localparam int NMW  = W + 2;
   localparam int NW   = NMW + FRAC_BITS;
   localparam int DW   = W + 1;
   localparam int OUTW = ((2 * W + 7) / 8) * 8;

   logic pipe_en;

   // ---------------- input stage: signs and magnitudes ----------------
   front_ctl_type s1_ctl_ff;
   logic [W-1:0]  s1_ma_ff, s1_mb_ff, s1_mc_ff;

   function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
      return v[W-1] ? W'(~v + 1'b1) : v;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (pipe_en) begin
         s1_ctl_ff.valid <= req_tvalid;
         s1_ctl_ff.sa    <= req_tdata[W-1];
         s1_ctl_ff.sb    <= req_tdata[2*W-1];
         s1_ctl_ff.sc    <= req_tdata[3*W-1];
         s1_ctl_ff.dneg  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_ma_ff <= mag_of(req_tdata[W-1:0]);
         s1_mb_ff <= mag_of(req_tdata[2*W-1:W]);
         s1_mc_ff <= mag_of(req_tdata[3*W-1:2*W]);
      end
   end

   // ---------------- products ----------------
   front_ctl_type  s2_ctl_ff;
   logic [W-1:0]   s2_ma_ff, s2_mb_ff;
   logic [2*W-1:0] s2_b2_ff, s2_ac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else if (pipe_en) begin
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_ma_ff <= s1_ma_ff;
         s2_mb_ff <= s1_mb_ff;
         s2_b2_ff <= {{W{1'b0}}, s1_mb_ff} * {{W{1'b0}}, s1_mb_ff};
         s2_ac_ff <= {{W{1'b0}}, s1_ma_ff} * {{W{1'b0}}, s1_mc_ff};
      end
   end

   // ---------------- discriminant ----------------
   front_ctl_type s3_ctl_ff;
   logic [W-1:0]  s3_ma_ff, s3_mb_ff;
   logic [RW-1:0] s3_dmag_ff;
   logic [RW-1:0] b2x, ac4, dmag_in;
   logic          dneg_in;

   assign b2x = {2'b00, s2_b2_ff};
   assign ac4 = {s2_ac_ff, 2'b00};

   always_comb begin
      if (s2_ctl_ff.sa != s2_ctl_ff.sc) begin
         dneg_in = 1'b0;
         dmag_in = b2x + ac4;
      end else if (b2x >= ac4) begin
         dneg_in = 1'b0;
         dmag_in = b2x - ac4;
      end else begin
         dneg_in = 1'b1;
         dmag_in = ac4 - b2x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else if (pipe_en) begin
         s3_ctl_ff.valid <= s2_ctl_ff.valid;
         s3_ctl_ff.sa    <= s2_ctl_ff.sa;
         s3_ctl_ff.sb    <= s2_ctl_ff.sb;
         s3_ctl_ff.sc    <= s2_ctl_ff.sc;
         s3_ctl_ff.dneg  <= dneg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_ma_ff   <= s2_ma_ff;
         s3_mb_ff   <= s2_mb_ff;
         s3_dmag_ff <= dmag_in;
      end
   end

   // ---------------- square root with side line ----------------
   logic [SQ-1:0] root;
   front_ctl_type sq_ctl_ff [SQ];
   logic [W-1:0]  sq_ma_ff  [SQ];
   logic [W-1:0]  sq_mb_ff  [SQ];

   qrs_isqrt #(.RAD_WIDTH(RW)) u_isqrt (
      .clock    (clock),
      .en       (pipe_en),
      .rad_in   (s3_dmag_ff),
      .root_out (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQ; k++) sq_ctl_ff[k] <= '0;
      end else if (pipe_en) begin
         sq_ctl_ff[0] <= s3_ctl_ff;
         for (int k = 1; k < SQ; k++) sq_ctl_ff[k] <= sq_ctl_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sq_ma_ff[0] <= s3_ma_ff;
         sq_mb_ff[0] <= s3_mb_ff;
         for (int k = 1; k < SQ; k++) begin
            sq_ma_ff[k] <= sq_ma_ff[k-1];
            sq_mb_ff[k] <= sq_mb_ff[k-1];
         end
      end
   end

   // ---------------- numerators ----------------
   front_ctl_type sq_ctl;
   logic [NMW-1:0] mbx, sx;
   logic [NMW:0]   n1, n2;
   logic           n1s, n2s;
   div_ctl_type    s4_ctl_ff;
   logic [NW-1:0]  s4_num1_ff, s4_num2_ff;
   logic [DW-1:0]  s4_den_ff;

   // Sign-magnitude sum; returns {sign, magnitude}, zero is never negative.
   function automatic logic [NMW:0] sm_add(input logic xs, input logic [NMW-1:0] xm,
                                           input logic ys, input logic [NMW-1:0] ym);
      logic [NMW-1:0] m;
      logic           s;
      if (xs == ys) begin
         m = xm + ym;
         s = xs;
      end else if (xm >= ym) begin
         m = xm - ym;
         s = xs;
      end else begin
         m = ym - xm;
         s = ys;
      end
      return {(m != '0) && s, m};
   endfunction

   assign sq_ctl = sq_ctl_ff[SQ-1];
   assign mbx    = NMW'(sq_mb_ff[SQ-1]);
   assign sx     = NMW'(root);

   always_comb begin
      if (!sq_ctl.dneg) begin
         n1 = sm_add(!sq_ctl.sb, mbx, 1'b0, sx);
         n2 = sm_add(!sq_ctl.sb, mbx, 1'b1, sx);
      end else begin
         n1 = {(mbx != '0) && !sq_ctl.sb, mbx};
         n2 = {1'b0, sx};
      end
   end

   assign n1s = n1[NMW];
   assign n2s = n2[NMW];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctl_ff <= '0;
      end else if (pipe_en) begin
         s4_ctl_ff.valid <= sq_ctl.valid;
         s4_ctl_ff.degen <= (sq_ma_ff[SQ-1] == '0);
         s4_ctl_ff.cplx  <= sq_ctl.dneg;
         s4_ctl_ff.neg1  <= n1s != sq_ctl.sa;
         s4_ctl_ff.neg2  <= n2s != sq_ctl.sa;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s4_num1_ff <= NW'(n1[NMW-1:0]) << FRAC_BITS;
         s4_num2_ff <= NW'(n2[NMW-1:0]) << FRAC_BITS;
         s4_den_ff  <= {sq_ma_ff[SQ-1], 1'b0};
      end
   end

   // ---------------- dividers with side line ----------------
   logic [NW-1:0] quo1, quo2;
   div_ctl_type   dv_ctl_ff [NW];

   qrs_div #(.NUM_WIDTH(NW), .DEN_WIDTH(DW)) u_div_first (
      .clock   (clock),
      .en      (pipe_en),
      .num_in  (s4_num1_ff),
      .den_in  (s4_den_ff),
      .quo_out (quo1)
   );

   qrs_div #(.NUM_WIDTH(NW), .DEN_WIDTH(DW)) u_div_second (
      .clock   (clock),
      .en      (pipe_en),
      .num_in  (s4_num2_ff),
      .den_in  (s4_den_ff),
      .quo_out (quo2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NW; k++) dv_ctl_ff[k] <= '0;
      end else if (pipe_en) begin
         dv_ctl_ff[0] <= s4_ctl_ff;
         for (int k = 1; k < NW; k++) dv_ctl_ff[k] <= dv_ctl_ff[k-1];
      end
   end

   // ---------------- saturation and output register ----------------
   div_ctl_type   dv_ctl;
   logic [W:0]    enc1, enc2;
   logic          out_valid_ff;
   logic [W-1:0]  first_ff, second_ff;
   root_kind_type kind_ff, kind_in;
   logic          sat_ff;

   // Returns {saturated, value}.
   function automatic logic [W:0] encode(input logic neg, input logic [NW-1:0] q);
      logic [NW-1:0] lim;
      logic [NW-1:0] m;
      logic          sat;
      lim = neg ? (NW'(1) << (W - 1)) : ((NW'(1) << (W - 1)) - NW'(1));
      sat = (q > lim);
      m   = sat ? lim : q;
      return {sat, neg ? W'(~m + NW'(1)) : W'(m)};
   endfunction

   assign dv_ctl = dv_ctl_ff[NW-1];
   assign enc1   = encode(dv_ctl.neg1, quo1);
   assign enc2   = encode(dv_ctl.neg2, quo2);

   always_comb begin
      if (dv_ctl.degen) kind_in = KIND_DEGENERATE;
      else if (dv_ctl.cplx) kind_in = KIND_COMPLEX;
      else kind_in = KIND_REAL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         out_valid_ff <= dv_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         kind_ff <= kind_in;
         if (dv_ctl.degen) begin
            first_ff  <= '0;
            second_ff <= '0;
            sat_ff    <= 1'b0;
         end else begin
            first_ff  <= enc1[W-1:0];
            second_ff <= enc2[W-1:0];
            sat_ff    <= enc1[W] | enc2[W];
         end
      end
   end

   // The whole pipeline moves together; it holds only while a result waits.
   assign pipe_en    = !out_valid_ff || rsp_tready;
   assign req_tready = pipe_en;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OUTW'({second_ff, first_ff});
   assign rsp_tuser  = {sat_ff, kind_ff};

endmodule
`default_nettype wire
